[rtl/wvm_pkg.sv]
// wvm_pkg: item codes, constants and the envelope decay arithmetic of the
// wavetable voice mixer. No dependencies; used by wvm_mac and the top level.

package wvm_pkg;

	// item function codes
	typedef enum logic [2:0] {
		FUNC_SAMPLE     = 3'd0,
		FUNC_NOTE_ON    = 3'd1,
		FUNC_ENV_TICK   = 3'd2,
		FUNC_WAVE_WRITE = 3'd3,
		FUNC_ENV_WRITE  = 3'd4,
		FUNC_CLEAR      = 3'd5
	} func_t;

	localparam int MIX_W = 12;                     // mix accumulator, eight voices
	localparam logic [7:0]  DIVIDE_RESET = 8'd130;
	localparam logic [7:0]  LEVEL_FULL   = 8'd255;
	localparam logic [7:0]  PWM_OFFSET   = 8'd128;
	localparam logic [7:0]  PWM_TOP      = 8'd255; // +127 clamped, plus offset
	localparam logic [7:0]  PWM_BOTTOM   = 8'd1;   // -127 clamped, plus offset
	localparam logic signed [MIX_W-1:0] MIX_MAX = 12'sd127;
	localparam logic signed [MIX_W-1:0] MIX_MIN = -12'sd127;
	localparam logic signed [16:0] STEP_BIAS    = 17'sd138;
	localparam logic signed [13:0] DECAY_OFFSET = 14'sd103;
	localparam logic [16:0] DECAY_LIMIT = 17'd32768;

	// New decay accumulator for one voice, held at the limit once reached
	function automatic logic [15:0] decay_sum(logic [15:0] step, logic [15:0] acc);
		logic signed [16:0] biased;
		logic signed [13:0] d;
		logic [11:0]        delta;
		logic [16:0]        s;
		biased = signed'({1'b0, step}) - STEP_BIAS;
		d      = 14'(biased >>> 4) + DECAY_OFFSET;   // 94 .. 4190, never negative
		delta  = 12'(d >>> 1);
		s      = {1'b0, acc} + 17'(delta);
		return (s >= DECAY_LIMIT) ? 16'(DECAY_LIMIT) : s[15:0];
	endfunction

endpackage

[rtl/wvm_ifs.sv]
// Valid/ready channels of the wavetable voice mixer: item in, result out.
// Depends on nothing; widths follow the item and result fields.

interface wvm_in_if;
	logic              valid;
	logic              ready;
	logic [2:0]        func;
	logic [2:0]        voice;
	logic [15:0]       note_step;
	logic [7:0]        skip_mask;
	logic [7:0]        table_addr;
	logic signed [7:0] wave_sample;
	logic [7:0]        env_value;

	modport source(output valid, func, voice, note_step, skip_mask, table_addr,
		wave_sample, env_value, input ready);
	modport sink(input valid, func, voice, note_step, skip_mask, table_addr,
		wave_sample, env_value, output ready);
endinterface

interface wvm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pwm_level;
	logic       ctrl_due;

	modport source(output valid, pwm_level, ctrl_due, input ready);
	modport sink(input valid, pwm_level, ctrl_due, output ready);
endinterface

[rtl/wvm_ram.sv]
// wvm_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.

module wvm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/wvm_mac.sv]
// wvm_mac: shared multiply, floor shift and accumulate unit for the voice mix.
// Depends on wvm_pkg for the accumulator width.

module wvm_mac (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            clear,
	input  logic                            en,
	input  logic signed [7:0]               sample,
	input  logic [7:0]                      level,
	output logic signed [wvm_pkg::MIX_W-1:0] acc,
	output logic                            busy
);

	logic signed [16:0]               prod_s2;
	logic                             prod_v_s2;
	logic signed [wvm_pkg::MIX_W-1:0] acc_q;
	logic signed [16:0]               prod;

	// signed wave sample times unsigned level
	assign prod = 17'(sample) * 17'(signed'({1'b0, level}));

	// product stage, then accumulate the floor-shifted product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_s2   <= '0;
			prod_v_s2 <= 1'b0;
			acc_q     <= '0;
		end else begin
			prod_v_s2 <= en;
			if (en) begin
				prod_s2 <= prod;
			end
			if (clear) begin
				acc_q <= '0;
			end else if (prod_v_s2) begin
				acc_q <= acc_q + wvm_pkg::MIX_W'(prod_s2 >>> 8);
			end
		end
	end

	assign acc  = acc_q;
	assign busy = prod_v_s2;

endmodule

[rtl/wavetable_voice_mixer.sv]
// Wavetable voice mixer top level: sequencer, voice state and the two tables.
// Depends on wvm_pkg, wvm_ifs (channels), wvm_ram and wvm_mac.
//
// A sample tick mixes the voices one per cycle through a single multiplier
// and the wave table read port; no further item is taken until the mix is
// finished. The result is then held in an output register while further
// items are accepted. A further sample tick waits at its end for as long as
// the previous result is still unclaimed. An envelope tick walks the voices
// through the envelope table read port, and no further item is taken until
// it has finished. Note-on, table writes and voice clear complete on their
// acceptance. The wave and envelope tables are not cleared by reset and must
// be loaded before they are read.

module wavetable_voice_mixer #(
	parameter int VOICES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	wvm_in_if.sink      item,
	wvm_out_if.source   result
);

	localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CW  = $clog2(VOICES + 1);
	localparam logic [CW-1:0] LAST = CW'(VOICES);

	typedef enum logic [1:0] {ST_IDLE, ST_MIX, ST_ENV} state_t;

	state_t           state_q;
	logic [CW-1:0]    iss_q;
	logic             rd_v_s1;
	logic             upd_s1;
	logic [VIW-1:0]   rd_idx_s1;
	logic [7:0]       skip_q;
	logic [15:0]      step_q  [VOICES];
	logic [15:0]      phase_q [VOICES];
	logic [7:0]       level_q [VOICES];
	logic [15:0]      decay_q [VOICES];
	logic [7:0]       cnt_q;
	logic [7:0]       div_q;
	logic             out_valid_q;
	logic [7:0]       pwm_q;
	logic             due_q;

	logic             accept;
	logic [VIW-1:0]   iss_idx;
	logic             issuing;
	logic [15:0]      dsum;
	logic [7:0]       env_idx;
	logic             env_upd;
	logic             slot_free;
	logic             mix_done;
	logic [7:0]       wave_rd;
	logic [7:0]       env_rd;
	logic signed [wvm_pkg::MIX_W-1:0] mix;
	logic             mac_busy;
	logic [7:0]       pwm_next;
	logic [7:0]       cnt_inc;
	logic             due_next;

	assign accept    = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);
	assign iss_idx   = iss_q[VIW-1:0];
	assign issuing   = (iss_q != LAST);
	assign slot_free = !out_valid_q || result.ready;
	assign mix_done  = (state_q == ST_MIX) && !issuing && !rd_v_s1 && !mac_busy && slot_free;

	// envelope step for the voice being visited
	assign dsum    = wvm_pkg::decay_sum(step_q[iss_idx], decay_q[iss_idx]);
	assign env_idx = dsum[15] ? 8'hFF : dsum[14:7];
	assign env_upd = (level_q[iss_idx] != '0) && !skip_q[3'(iss_idx)];

	// wave table
	wvm_ram #(.WIDTH(8), .DEPTH(256)) u_wave_ram (
		.clk   (clk),
		.we    (accept && (item.func == wvm_pkg::FUNC_WAVE_WRITE)),
		.waddr (item.table_addr),
		.wdata (item.wave_sample),
		.re    ((state_q == ST_MIX) && issuing),
		.raddr (phase_q[iss_idx][15:8]),
		.rdata (wave_rd)
	);

	// envelope table
	wvm_ram #(.WIDTH(8), .DEPTH(256)) u_env_ram (
		.clk   (clk),
		.we    (accept && (item.func == wvm_pkg::FUNC_ENV_WRITE)),
		.waddr (item.table_addr),
		.wdata (item.env_value),
		.re    ((state_q == ST_ENV) && issuing && env_upd),
		.raddr (env_idx),
		.rdata (env_rd)
	);

	// shared multiply-accumulate
	wvm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (accept && (item.func == wvm_pkg::FUNC_SAMPLE)),
		.en     ((state_q == ST_MIX) && rd_v_s1),
		.sample (signed'(wave_rd)),
		.level  (level_q[rd_idx_s1]),
		.acc    (mix),
		.busy   (mac_busy)
	);

	// clamp to +/-127 and offset; sample counter
	always_comb begin
		if (mix > wvm_pkg::MIX_MAX) begin
			pwm_next = wvm_pkg::PWM_TOP;
		end else if (mix < wvm_pkg::MIX_MIN) begin
			pwm_next = wvm_pkg::PWM_BOTTOM;
		end else begin
			pwm_next = mix[7:0] + wvm_pkg::PWM_OFFSET;
		end
		cnt_inc  = cnt_q + 8'd1;
		due_next = (cnt_inc >= div_q);
	end

	// sequencer, voice state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iss_q       <= '0;
			rd_v_s1     <= 1'b0;
			upd_s1      <= 1'b0;
			rd_idx_s1   <= '0;
			skip_q      <= '0;
			cnt_q       <= '0;
			div_q       <= wvm_pkg::DIVIDE_RESET;
			out_valid_q <= 1'b0;
			pwm_q       <= '0;
			due_q       <= 1'b0;
			for (int i = 0; i < VOICES; i++) begin
				step_q[i]  <= '0;
				phase_q[i] <= '0;
				level_q[i] <= '0;
				decay_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				div_q <= cfg_wdata;
			end
			// a finishing mix refills the slot itself
			if (result.ready && !mix_done) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					rd_v_s1 <= 1'b0;
					upd_s1  <= 1'b0;
					if (accept) begin
						unique case (item.func)
							wvm_pkg::FUNC_SAMPLE: begin
								iss_q   <= '0;
								state_q <= ST_MIX;
							end
							wvm_pkg::FUNC_NOTE_ON: begin
								if (32'(item.voice) < VOICES) begin
									step_q[item.voice[VIW-1:0]]  <= item.note_step;
									phase_q[item.voice[VIW-1:0]] <= '0;
									level_q[item.voice[VIW-1:0]] <= wvm_pkg::LEVEL_FULL;
									decay_q[item.voice[VIW-1:0]] <= '0;
								end
							end
							wvm_pkg::FUNC_ENV_TICK: begin
								skip_q  <= item.skip_mask;
								iss_q   <= '0;
								state_q <= ST_ENV;
							end
							wvm_pkg::FUNC_CLEAR: begin
								for (int i = 0; i < VOICES; i++) begin
									step_q[i]  <= '0;
									phase_q[i] <= '0;
									level_q[i] <= '0;
									decay_q[i] <= '0;
								end
							end
							default: begin
								// table writes go straight to the RAMs
							end
						endcase
					end
				end
				ST_MIX: begin
					rd_v_s1   <= issuing;
					rd_idx_s1 <= iss_idx;
					if (issuing) begin
						phase_q[iss_idx] <= phase_q[iss_idx] + step_q[iss_idx];
						iss_q            <= iss_q + CW'(1);
					end else if (mix_done) begin
						out_valid_q <= 1'b1;
						pwm_q       <= pwm_next;
						due_q       <= due_next;
						cnt_q       <= due_next ? 8'd0 : cnt_inc;
						state_q     <= ST_IDLE;
					end
				end
				ST_ENV: begin
					rd_v_s1   <= issuing;
					upd_s1    <= issuing && env_upd;
					rd_idx_s1 <= iss_idx;
					if (issuing) begin
						if (env_upd) begin
							decay_q[iss_idx] <= dsum;
						end
						iss_q <= iss_q + CW'(1);
					end
					if (upd_s1) begin
						level_q[rd_idx_s1] <= env_rd;
					end
					if (!issuing && !rd_v_s1) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid     = out_valid_q;
	assign result.pwm_level = pwm_q;
	assign result.ctrl_due  = due_q;

	// the voice counter never runs past the last voice
	a_iss_range: assert property (@(posedge clk) disable iff (!arst_n)
		iss_q <= LAST)
		else $error("voice counter out of range");

	// a finished mix always presents a result on the next cycle
	a_mix_result: assert property (@(posedge clk) disable iff (!arst_n)
		mix_done |=> (result.valid && (state_q == ST_IDLE)))
		else $error("finished mix produced no result");

	// a raised control flag restarts the sample counter
	a_due_restart: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid_q) && due_q) |-> (cnt_q == '0))
		else $error("sample counter not restarted on control flag");

	// the multiplier is idle throughout an envelope tick
	a_env_mac_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENV) |-> !mac_busy)
		else $error("mix pipeline busy during envelope tick");

endmodule
